FILE: design/cpneg_pkg.sv
// Shared types and constants for the chord pair note event generator.
`timescale 1ns / 1ps
`default_nettype none

package cpneg_pkg;

    localparam int NUM_LIMITS  = 5;
    localparam int NUM_PAIRS   = 6;
    localparam int NUM_CHORDS  = 6;
    localparam int ROM_NOTES   = 4;
    localparam int NOTE_W      = 7;
    localparam int LIMIT_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int PAIR_W      = 3;
    localparam int CHORD_W     = 3;
    localparam int SHIFT_W     = 9;

    localparam logic [SHIFT_W-1:0] CENTER_NOTE = 9'd60;
    localparam logic [NOTE_W-1:0]  TOP_NOTE    = 7'd127;
    localparam int                 OCTAVE      = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ONE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_TWO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_THREE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_FOUR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_FIVE  = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_LIMITS] = '{
        8'd21, 8'd42, 8'd63, 8'd84, 8'd105
    };

    // Chords in order: Dm7, G7, Cmaj7, Fmaj7, Am7, Em7.
    localparam logic [NOTE_W-1:0] CHORD_ROM [NUM_CHORDS][ROM_NOTES] = '{
        '{7'd62, 7'd65, 7'd69, 7'd72},
        '{7'd67, 7'd71, 7'd74, 7'd77},
        '{7'd60, 7'd64, 7'd67, 7'd71},
        '{7'd65, 7'd69, 7'd72, 7'd76},
        '{7'd69, 7'd72, 7'd76, 7'd79},
        '{7'd64, 7'd67, 7'd71, 7'd74}
    };

    // First and second chord of each pair.
    localparam logic [CHORD_W-1:0] PAIR_TABLE [NUM_PAIRS][2] = '{
        '{3'd0, 3'd1}, '{3'd5, 3'd4}, '{3'd4, 3'd0},
        '{3'd3, 3'd1}, '{3'd1, 3'd2}, '{3'd2, 3'd0}
    };

    typedef enum logic [1:0] {
        PH_ON1  = 2'd0,
        PH_OFF1 = 2'd1,
        PH_ON2  = 2'd2,
        PH_OFF2 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [6:0] error_level;
        logic [6:0] base_note;
    } request_t;

    typedef struct packed {
        logic       note_on;
        logic [6:0] note_number;
        logic       chord_slot;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

FILE: design/chord_pair_note_event_generator.sv
// Top level of the chord pair note event generator.
//
//  Channel   Signals                              Transaction
//  --------  -----------------------------------  ----------------------------------
//  request   start, busy, request                 start high and busy low at an edge
//  result    result_strobe, result                result_strobe high at an edge, no stall
//  config    cfg_we, cfg_index, cfg_data          cfg_we high at an edge
//
// A request is registered at acceptance and its chords are resolved in the next cycle;
// with the sequencer idle they are loaded into the sequencer and the first event goes out via out_reg.
// A request produces 2 * (n1 + n2) events, at most 16, one per cycle from a single
// event sequencer; a request with no notes in range gives none.
// A waiting request is loaded as the last event of the previous run is registered, so
// runs follow with no gap; reset restores the limits and leaves no request pending.
`timescale 1ns / 1ps
`default_nettype none

module chord_pair_note_event_generator
    import cpneg_pkg::*;
#(
    parameter int NOTES_PER_CHORD = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire request_t               request,
    output logic                        result_strobe,
    output result_t                     result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]     cfg_data
);

    localparam int KEEP = (NOTES_PER_CHORD < ROM_NOTES) ? NOTES_PER_CHORD : ROM_NOTES;
    localparam int CW   = $clog2(KEEP + 1);
    localparam int IW   = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam logic [CW-1:0] KEEP_C = CW'(KEEP);

    function automatic logic is_clash(input logic [NOTE_W-1:0] a,
                                      input logic [NOTE_W-1:0] b);
        logic [NOTE_W-1:0] ad;
        logic              hit;
        ad  = (a > b) ? (a - b) : (b - a);
        hit = 1'b0;
        for (int k = 0; k * OCTAVE + 1 <= 127; k++)
        begin
            if (ad == NOTE_W'(k * OCTAVE + 1))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    logic [LIMIT_W-1:0] limit_reg [NUM_LIMITS];

    logic     in_valid_reg;
    logic     in_valid_next;
    request_t in_reg;

    logic                active_reg;
    logic                active_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [CW-1:0]       cnt_reg  [2];
    logic [NOTE_W-1:0]   kept_reg [2][KEEP];

    logic                out_valid_reg;
    result_t             out_reg;
    result_t             out_next;

    logic                 accept;
    logic                 load;
    logic                 emit_free;
    logic [PAIR_W-1:0]    pair;
    logic signed [SHIFT_W-1:0] shift;
    logic signed [SHIFT_W-1:0] note_t;
    logic [CHORD_W-1:0]   chord;
    logic                 ok;
    logic [CW-1:0]        cnt;
    logic [CW-1:0]        cnt_new  [2];
    logic [NOTE_W-1:0]    kept_new [2][KEEP];

    logic                 cur_slot;
    logic [CW-1:0]        cur_cnt;
    logic [NOTE_W-1:0]    cur_note;
    logic                 at_end;
    logic                 run_end;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LIMITS; i++)
            begin
                limit_reg[i] <= LIMIT_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LIMIT_ONE:   limit_reg[0] <= cfg_data;
                REG_LIMIT_TWO:   limit_reg[1] <= cfg_data;
                REG_LIMIT_THREE: limit_reg[2] <= cfg_data;
                REG_LIMIT_FOUR:  limit_reg[3] <= cfg_data;
                REG_LIMIT_FIVE:  limit_reg[4] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Chord pair selection, transposition and note filtering for the held request.
    always_comb
    begin
        pair = PAIR_W'(NUM_PAIRS - 1);
        for (int i = NUM_LIMITS - 1; i >= 0; i--)
        begin
            if ({1'b0, in_reg.error_level} < limit_reg[i])
            begin
                pair = PAIR_W'(i);
            end
        end
        shift  = $signed({2'b00, in_reg.base_note}) - $signed(CENTER_NOTE);
        chord  = '0;
        note_t = '0;
        ok     = 1'b0;
        cnt    = '0;
        for (int s = 0; s < 2; s++)
        begin
            chord = PAIR_TABLE[pair][s];
            cnt   = '0;
            for (int j = 0; j < KEEP; j++)
            begin
                kept_new[s][j] = '0;
            end
            for (int i = 0; i < ROM_NOTES; i++)
            begin
                note_t = $signed({2'b00, CHORD_ROM[chord][i]}) + shift;
                ok = (note_t >= 0) && (note_t <= $signed({2'b00, TOP_NOTE})) &&
                     (cnt < KEEP_C);
                for (int j = 0; j < KEEP; j++)
                begin
                    if ((CW'(j) < cnt) && is_clash(note_t[NOTE_W-1:0], kept_new[s][j]))
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    for (int j = 0; j < KEEP; j++)
                    begin
                        if (CW'(j) == cnt)
                        begin
                            kept_new[s][j] = note_t[NOTE_W-1:0];
                        end
                    end
                    cnt = cnt + 1'b1;
                end
            end
            cnt_new[s] = cnt;
        end
    end

    // Event sequencer.
    always_comb
    begin
        cur_slot = (phase_reg == PH_ON2) || (phase_reg == PH_OFF2);
        cur_cnt  = cnt_reg[cur_slot];
        cur_note = kept_reg[cur_slot][idx_reg[IW-1:0]];
        at_end   = (CW'(idx_reg + 1'b1) == cur_cnt);
        run_end  = at_end && ((phase_reg == PH_OFF2) ||
                              ((phase_reg == PH_OFF1) && (cnt_reg[1] == '0)));
        emit_free = !active_reg || run_end;
        load      = in_valid_reg && emit_free;
        accept    = start && !(in_valid_reg && !emit_free);

        in_valid_next = accept ? 1'b1 : (load ? 1'b0 : in_valid_reg);

        active_next = active_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        if (active_reg)
        begin
            if (at_end)
            begin
                idx_next = '0;
                case (phase_reg)
                    PH_ON1:
                    begin
                        phase_next = PH_OFF1;
                    end
                    PH_OFF1:
                    begin
                        if (cnt_reg[1] != '0)
                        begin
                            phase_next = PH_ON2;
                        end
                        else
                        begin
                            active_next = 1'b0;
                        end
                    end
                    PH_ON2:
                    begin
                        phase_next = PH_OFF2;
                    end
                    default:
                    begin
                        active_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                idx_next = CW'(idx_reg + 1'b1);
            end
        end
        if (load)
        begin
            active_next = (cnt_new[0] != '0) || (cnt_new[1] != '0);
            phase_next  = (cnt_new[0] != '0) ? PH_ON1 : PH_ON2;
            idx_next    = '0;
        end

        out_next.note_on     = (phase_reg == PH_ON1) || (phase_reg == PH_ON2);
        out_next.note_number = cur_note;
        out_next.chord_slot  = cur_slot;
        out_next.last        = run_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            active_reg    <= 1'b0;
            phase_reg     <= PH_ON1;
            idx_reg       <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= active_reg;
            if (load)
            begin
                cnt_reg[0] <= cnt_new[0];
                cnt_reg[1] <= cnt_new[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= request;
        end
        if (load)
        begin
            kept_reg <= kept_new;
        end
        out_reg <= out_next;
    end

    assign busy          = in_valid_reg && !emit_free;
    assign result_strobe = out_valid_reg;
    assign result        = out_reg;

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |=> result_strobe)
        else $error("event run broken before its last transaction");

    a_active_has_notes: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_cnt != '0))
        else $error("sequencer active on an empty chord");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted transaction was not registered");

    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (in_valid_reg && active_reg))
        else $error("busy without a pending transaction and a running sequencer");

endmodule

`default_nettype wire
